// ===== hw/rtl/pcfc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pcfc_pkg
// Shared types and constants for the parallel camera frame capture block.
// ----------------------------------------------------------------------------
package pcfc_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;

   localparam int DIM_W   = 11;
   localparam int INDEX_W = 20;
   localparam int BYTE_W  = 8;

   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 40;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // register select is paddr bit 2
   localparam logic REG_FRAME_WIDTH  = 1'b0;
   localparam logic REG_FRAME_HEIGHT = 1'b1;

   localparam logic [DIM_W-1:0] RESET_WIDTH  = DIM_W'(640);
   localparam logic [DIM_W-1:0] RESET_HEIGHT = DIM_W'(480);

   typedef struct packed {
      logic [DIM_W-1:0] frame_width;
      logic [DIM_W-1:0] frame_height;
   } cfg_type;

endpackage
`default_nettype wire

// ===== hw/rtl/parallel_camera_frame_capture_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// parallel_camera_frame_capture_core
// Captures two-byte pixels from sampled parallel camera lines.
// ----------------------------------------------------------------------------
// output: a result is registered and is in the output register in the cycle after its request is taken
// throughput: one request per cycle; a request is taken while the output
//    register is empty or being drained in the same cycle
// reset: synchronous; waits for a vsync pulse, width 640 and height 480
// ----------------------------------------------------------------------------
module parallel_camera_frame_capture_core
   import pcfc_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   // req_tdata: vsync_level, href_level, pclk_level, data_byte[7:0], zero fill
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   // rsp_tdata: pixel_index[19:0], high_byte[7:0], low_byte[7:0], zero fill
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic      [RSP_TDATA_W-1:0] rsp_tdata,
   // rsp_tuser: pixel_valid
   output logic                        rsp_tuser,
   output logic                        rsp_tlast,
   input  wire logic                   csr_psel,
   input  wire logic                   csr_penable,
   input  wire logic                   csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic      [CSR_DATA_W-1:0]  csr_prdata,
   output logic                        csr_pready
);

   cfg_type            cfg;
   logic               req_fire;
   logic [INDEX_W-1:0] pixel_index;
   logic [BYTE_W-1:0]  high_byte;
   logic [BYTE_W-1:0]  low_byte;

   pcfc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   assign req_tready = ~rsp_tvalid | rsp_tready;
   assign req_fire   = req_tvalid & req_tready;

   pcfc_capture u_capture (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .req_fire        (req_fire),
      .vsync           (req_tdata[0]),
      .href            (req_tdata[1]),
      .pclk            (req_tdata[2]),
      .data            (req_tdata[10:3]),
      .rsp_tready      (rsp_tready),
      .rsp_tvalid      (rsp_tvalid),
      .out_pixel_valid (rsp_tuser),
      .out_pixel_index (pixel_index),
      .out_high_byte   (high_byte),
      .out_low_byte    (low_byte),
      .out_frame_end   (rsp_tlast)
   );

   assign rsp_tdata = {4'b0000, low_byte, high_byte, pixel_index};

endmodule
`default_nettype wire

// ===== hw/rtl/pcfc_csr.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pcfc_csr
// Configuration registers for frame width and height behind an APB-style port.
// ----------------------------------------------------------------------------
module pcfc_csr
   import pcfc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready,
   output cfg_type                    cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (csr_paddr[2])
            REG_FRAME_WIDTH:  cfg_in.frame_width  = csr_pwdata[DIM_W-1:0];
            REG_FRAME_HEIGHT: cfg_in.frame_height = csr_pwdata[DIM_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width  <= RESET_WIDTH;
         cfg_ff.frame_height <= RESET_HEIGHT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_FRAME_WIDTH:  csr_prdata = CSR_DATA_W'(cfg_ff.frame_width);
         REG_FRAME_HEIGHT: csr_prdata = CSR_DATA_W'(cfg_ff.frame_height);
         default:          csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/pcfc_capture.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pcfc_capture
// Frame/row/pixel tracking on sampled camera lines with a result register.
// ----------------------------------------------------------------------------
module pcfc_capture
   import pcfc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cfg_type           cfg,
   input  wire logic              req_fire,
   input  wire logic              vsync,
   input  wire logic              href,
   input  wire logic              pclk,
   input  wire logic [BYTE_W-1:0] data,
   input  wire logic              rsp_tready,
   output logic                   rsp_tvalid,
   output logic                   out_pixel_valid,
   output logic      [INDEX_W-1:0] out_pixel_index,
   output logic      [BYTE_W-1:0] out_high_byte,
   output logic      [BYTE_W-1:0] out_low_byte,
   output logic                   out_frame_end
);

   typedef enum logic [1:0] {
      PH_WAIT_HIGH = 2'd0,
      PH_WAIT_LOW  = 2'd1,
      PH_CAPTURE   = 2'd2
   } phase_type;

   phase_type           phase_ff, phase_in;
   logic                await_ff, await_in;
   logic                href_ff, href_in;
   logic                pclk_ff, pclk_in;
   logic [BYTE_W-1:0]   held_ff, held_in;
   logic [DIM_W-1:0]    col_ff, col_in;
   logic [DIM_W-1:0]    row_ff, row_in;
   logic [INDEX_W-1:0]  base_ff, base_in;

   logic                valid_ff, valid_in;
   logic                pv_ff, pv_in;
   logic [INDEX_W-1:0]  idx_ff, idx_in;
   logic [BYTE_W-1:0]   hi_ff, hi_in;
   logic [BYTE_W-1:0]   lo_ff, lo_in;
   logic                fe_ff, fe_in;

   logic [DIM_W-1:0]    eff_width;
   logic [DIM_W-1:0]    eff_height;
   logic [DIM_W-1:0]    row_next;
   logic                pclk_rise;
   logic                emit;

   always_comb begin
      eff_width  = (cfg.frame_width < DIM_W'(MAX_WIDTH)) ? cfg.frame_width
                                                         : DIM_W'(MAX_WIDTH);
      eff_height = (cfg.frame_height < DIM_W'(MAX_HEIGHT)) ? cfg.frame_height
                                                           : DIM_W'(MAX_HEIGHT);
      if (eff_height == '0) begin
         eff_height = DIM_W'(1);
      end
   end

   assign pclk_rise = pclk & ~pclk_ff;
   assign row_next  = row_ff + DIM_W'(1);

   always_comb begin
      phase_in = phase_ff;
      await_in = await_ff;
      href_in  = href_ff;
      pclk_in  = pclk_ff;
      held_in  = held_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      base_in  = base_ff;
      emit     = 1'b0;
      pv_in    = 1'b0;
      idx_in   = '0;
      hi_in    = '0;
      lo_in    = '0;
      fe_in    = 1'b0;

      unique case (phase_ff)
         PH_WAIT_LOW: begin
            if (!vsync) begin
               phase_in = PH_CAPTURE;
               await_in = 1'b0;
               href_in  = 1'b0;
               pclk_in  = 1'b0;
               held_in  = '0;
               col_in   = '0;
               row_in   = '0;
               base_in  = '0;
            end
         end
         PH_CAPTURE: begin
            if (await_ff) begin
               pclk_in = pclk;
               if (pclk_rise) begin
                  await_in = 1'b0;
                  if (col_ff < eff_width) begin
                     emit   = 1'b1;
                     pv_in  = 1'b1;
                     idx_in = base_ff + INDEX_W'(col_ff);
                     hi_in  = held_ff;
                     lo_in  = data;
                     col_in = col_ff + DIM_W'(1);
                  end
               end
            end else begin
               if (href && !href_ff) begin
                  col_in = '0;
               end
               if (href) begin
                  if (pclk_rise) begin
                     held_in  = data;
                     await_in = 1'b1;
                  end
                  pclk_in = pclk;
               end
               href_in = href;
               if (!href && href_ff) begin
                  row_in  = row_next;
                  base_in = base_ff + INDEX_W'(eff_width);
                  if (row_next >= eff_height) begin
                     phase_in = PH_WAIT_HIGH;
                     emit     = 1'b1;
                     fe_in    = 1'b1;
                  end
               end
            end
         end
         default: begin
            if (vsync) begin
               phase_in = PH_WAIT_LOW;
            end
         end
      endcase
   end

   always_comb begin
      valid_in = valid_ff & ~rsp_tready;
      if (req_fire) begin
         valid_in = emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_WAIT_HIGH;
         await_ff <= 1'b0;
         href_ff  <= 1'b0;
         pclk_ff  <= 1'b0;
         held_ff  <= '0;
         col_ff   <= '0;
         row_ff   <= '0;
         base_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (req_fire) begin
            phase_ff <= phase_in;
            await_ff <= await_in;
            href_ff  <= href_in;
            pclk_ff  <= pclk_in;
            held_ff  <= held_in;
            col_ff   <= col_in;
            row_ff   <= row_in;
            base_ff  <= base_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && emit) begin
         pv_ff  <= pv_in;
         idx_ff <= idx_in;
         hi_ff  <= hi_in;
         lo_ff  <= lo_in;
         fe_ff  <= fe_in;
      end
   end

   assign rsp_tvalid      = valid_ff;
   assign out_pixel_valid = pv_ff;
   assign out_pixel_index = idx_ff;
   assign out_high_byte   = hi_ff;
   assign out_low_byte    = lo_ff;
   assign out_frame_end   = fe_ff;

endmodule
`default_nettype wire
